// File: rtl/core/cdc_pkg.sv
// Package with shared constants and hash helpers for the chunking block.
package cdc_pkg;

    localparam int BufBytes = 4096;
    localparam int WinBytes = 64;
    localparam int Segments = 32;
    localparam int AddrW    = $clog2(BufBytes);
    localparam int OffW     = 13;
    localparam int SegW     = (Segments > 1) ? $clog2(Segments) : 1;
    localparam int SumW     = 14;

    localparam logic [31:0] MmC1 = 32'hcc9e2d51;
    localparam logic [31:0] MmC2 = 32'h1b873593;
    localparam logic [31:0] MmN  = 32'he6546b64;
    localparam logic [31:0] MmF1 = 32'h85ebca6b;
    localparam logic [31:0] MmF2 = 32'hc2b2ae35;

    localparam logic [9:0]  MaskReset  = 10'd859;
    localparam logic [9:0]  MatchReset = 10'd330;

    localparam logic [1:0] RegMask  = 2'd0;
    localparam logic [1:0] RegMatch = 2'd1;
    localparam logic [1:0] RegSeed  = 2'd2;

    function automatic logic [31:0] rotl(input logic [31:0] x, input int r);
        rotl = (x << r) | (x >> (32 - r));
    endfunction

endpackage

// File: rtl/core/cdc_mul.sv
// Shared 32x32 multiplier (low product) with a registered result.
module cdc_mul (
    input  logic        aclk,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic [31:0] p_reg
);
    always_ff @(posedge aclk) begin
        p_reg <= a * b;
    end
endmodule

// File: rtl/core/chunk_boundary_and_hash_top.sv
// Top level of the content-defined chunking and MurmurHash3 block.
// Bytes are taken one per cycle on the s_ channel into a 4096-byte buffer
// memory while the buffer fills. When the final byte is accepted, the block
// becomes busy. It first sums the opening 64-byte window at one byte per
// cycle. It then sweeps the remaining window starts with two memory reads
// and one update per start over 2048 starts, and records per segment the end
// of the window at the last matching start. It then hashes each chunk with
// one shared multiplier under a small sequencer: each byte is read and then
// gathered, each 4-byte block takes two multiply steps and a mix, and each
// segment adds setup, tail mixing, finalization and output. It delivers one
// m_ transfer per segment, 32 in all, the final one flagged by m_last_result,
// and waits in the output step while the receiver stalls. No byte is
// accepted until the last result is placed in the m_ output register.
// Configuration must be written by the user through the APB port only
// while the block is idle; the block does not enforce this.
module chunk_boundary_and_hash_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [12:0] m_boundary_end,
    output logic [31:0] m_chunk_hash,
    output logic        m_last_result
);
    localparam int AW = cdc_pkg::AddrW;
    localparam int OW = cdc_pkg::OffW;
    localparam int SW = cdc_pkg::SegW;
    localparam int NStarts = (cdc_pkg::BufBytes - cdc_pkg::WinBytes + 1 <
                              cdc_pkg::Segments * cdc_pkg::WinBytes) ?
                             (cdc_pkg::BufBytes - cdc_pkg::WinBytes + 1) :
                             (cdc_pkg::Segments * cdc_pkg::WinBytes);

    typedef enum logic [4:0] {
        S_FILL, S_W_RD, S_W_ADD, S_S_RDA, S_S_RDB, S_S_UPD,
        S_SEG, S_BLK_RD, S_BLK_GET, S_K1, S_K2, S_H, S_TAIL,
        S_F1, S_F1W, S_F2, S_F2W, S_OUT
    } state_t;

    // Configuration registers.
    logic [9:0]  mask_reg, match_reg;
    logic [31:0] seed_reg;
    assign pready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg  <= cdc_pkg::MaskReset;
            match_reg <= cdc_pkg::MatchReset;
            seed_reg  <= '0;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[3:2])
                cdc_pkg::RegMask:  mask_reg  <= pwdata[9:0];
                cdc_pkg::RegMatch: match_reg <= pwdata[9:0];
                cdc_pkg::RegSeed:  seed_reg  <= pwdata;
                default: ;
            endcase
        end
    end
    always_comb begin
        unique case (paddr[3:2])
            cdc_pkg::RegMask:  prdata = {22'd0, mask_reg};
            cdc_pkg::RegMatch: prdata = {22'd0, match_reg};
            cdc_pkg::RegSeed:  prdata = seed_reg;
            default:           prdata = '0;
        endcase
    end

    // Byte buffer memory, one read port with registered data.
    logic [7:0]    mem [cdc_pkg::BufBytes];
    logic [AW-1:0] rd_addr;
    logic [7:0]    rd_data_reg;
    logic          s_fire;
    logic [AW:0]   fill_reg;
    assign s_fire = s_valid && s_ready;
    always_ff @(posedge aclk) begin
        if (s_fire) mem[fill_reg[AW-1:0]] <= s_data_byte;
        rd_data_reg <= mem[rd_addr];
    end

    logic [31:0] mul_a, mul_b, mul_p;
    cdc_mul u_mul (.aclk(aclk), .a(mul_a), .b(mul_b), .p_reg(mul_p));

    state_t          state_reg;
    logic [OW-1:0]   table_reg [cdc_pkg::Segments];
    logic [cdc_pkg::SumW-1:0] sum_reg;
    logic [AW:0]     idx_reg;
    logic [7:0]      old_reg;
    logic [SW-1:0]   seg_reg;
    logic [OW-1:0]   prev_reg, bnd_reg, len_reg, pos_reg;
    logic [1:0]      bi_reg;
    logic [31:0]     k_reg, h_reg;
    logic [12:0]     o_bnd_reg;
    logic [31:0]     o_hash_reg;
    logic            o_last_reg, o_valid_reg;

    assign s_ready        = (state_reg == S_FILL);
    assign m_valid        = o_valid_reg;
    assign m_boundary_end = o_bnd_reg;
    assign m_chunk_hash   = o_hash_reg;
    assign m_last_result  = o_last_reg;

    logic [cdc_pkg::SumW-1:0] sx_new, sx_old;
    assign sx_new = {{(cdc_pkg::SumW-8){rd_data_reg[7]}}, rd_data_reg};
    assign sx_old = {{(cdc_pkg::SumW-8){old_reg[7]}}, old_reg};

    logic [OW-1:0] blk_end;
    assign blk_end = prev_reg + len_reg;

    // The chunk length is folded into the hash just before the first final mix.
    logic [31:0] h_len;
    assign h_len = h_reg ^ 32'(len_reg);

    always_comb begin
        rd_addr = idx_reg[AW-1:0];
        unique case (state_reg)
            S_S_RDA: rd_addr = AW'(idx_reg - (AW+1)'(1));
            S_S_RDB: rd_addr = AW'(idx_reg + (AW+1)'(cdc_pkg::WinBytes - 1));
            S_BLK_RD: rd_addr = AW'(pos_reg);
            default: ;
        endcase
        mul_a = k_reg;
        mul_b = cdc_pkg::MmC1;
        unique case (state_reg)
            S_K2: begin mul_a = cdc_pkg::rotl(mul_p, 15); mul_b = cdc_pkg::MmC2; end
            S_F1: begin mul_a = h_len ^ (h_len >> 16); mul_b = cdc_pkg::MmF1; end
            S_F2: begin mul_a = h_reg ^ (h_reg >> 13); mul_b = cdc_pkg::MmF2; end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_FILL;
            fill_reg    <= '0;
            o_valid_reg <= 1'b0;
            for (int i = 0; i < cdc_pkg::Segments; i++) table_reg[i] <= '0;
        end else begin
            unique case (state_reg)
                S_FILL: if (s_fire) begin
                    if (fill_reg == (AW+1)'(cdc_pkg::BufBytes - 1)) begin
                        fill_reg  <= '0;
                        idx_reg   <= '0;
                        sum_reg   <= '0;
                        state_reg <= S_W_RD;
                    end else fill_reg <= fill_reg + 1'b1;
                end
                // First window: one byte per cycle, read data registered and added in the cycle after its address.
                S_W_RD: state_reg <= S_W_ADD;
                S_W_ADD: begin
                    if (idx_reg != '0) sum_reg <= sum_reg + sx_new;
                    if (idx_reg == (AW+1)'(cdc_pkg::WinBytes)) begin
                        idx_reg   <= '0;
                        state_reg <= S_S_UPD;
                    end else begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= S_W_ADD;
                    end
                end
                S_S_RDA: state_reg <= S_S_RDB;
                S_S_RDB: begin old_reg <= rd_data_reg; state_reg <= S_S_UPD; end
                S_S_UPD: begin
                    // At start zero the sum is already complete.
                    logic [cdc_pkg::SumW-1:0] s;
                    s = (idx_reg == '0) ? sum_reg : sum_reg + sx_new - sx_old;
                    sum_reg <= s;
                    if ((s[9:0] & mask_reg) == match_reg)
                        table_reg[SW'(idx_reg / cdc_pkg::WinBytes)] <=
                            OW'(idx_reg + (AW+1)'(cdc_pkg::WinBytes));
                    if (idx_reg == (AW+1)'(NStarts - 1)) begin
                        seg_reg   <= '0;
                        prev_reg  <= '0;
                        state_reg <= S_SEG;
                    end else begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= S_S_RDA;
                    end
                end
                S_SEG: begin
                    bnd_reg <= table_reg[seg_reg];
                    len_reg <= table_reg[seg_reg] - prev_reg;
                    pos_reg <= prev_reg;
                    if (table_reg[seg_reg] == '0) begin
                        h_reg     <= '0;
                        state_reg <= S_OUT;
                    end else begin
                        h_reg     <= seed_reg;
                        bi_reg    <= '0;
                        k_reg     <= '0;
                        state_reg <= S_BLK_RD;
                    end
                end
                S_BLK_RD: begin
                    if (blk_end - pos_reg < OW'(4) && bi_reg == '0 &&
                        blk_end == pos_reg) state_reg <= S_F1;
                    else state_reg <= S_BLK_GET;
                end
                S_BLK_GET: begin
                    k_reg   <= k_reg | (32'(rd_data_reg) << {bi_reg, 3'b000});
                    pos_reg <= pos_reg + 1'b1;
                    bi_reg  <= bi_reg + 1'b1;
                    if (bi_reg == 2'd3 || pos_reg + 1'b1 == blk_end) state_reg <= S_K1;
                    else state_reg <= S_BLK_RD;
                end
                S_K1: state_reg <= S_K2;
                S_K2: state_reg <= (bi_reg == 2'd0 && pos_reg != blk_end) ||
                                   (bi_reg == 2'd0 && pos_reg == blk_end &&
                                    len_reg[1:0] == 2'd0) ? S_H : S_TAIL;
                S_H: begin
                    logic [31:0] t;
                    t = cdc_pkg::rotl(h_reg ^ mul_p, 13);
                    h_reg  <= 32'(t * 32'd5) + cdc_pkg::MmN;
                    k_reg  <= '0;
                    bi_reg <= '0;
                    state_reg <= (pos_reg == blk_end) ? S_F1 : S_BLK_RD;
                end
                S_TAIL: begin
                    h_reg     <= h_reg ^ mul_p;
                    state_reg <= S_F1;
                end
                S_F1: state_reg <= S_F1W;
                S_F1W: begin h_reg <= mul_p; state_reg <= S_F2; end
                S_F2: state_reg <= S_F2W;
                S_F2W: begin
                    h_reg     <= mul_p ^ (mul_p >> 16);
                    prev_reg  <= bnd_reg;
                    state_reg <= S_OUT;
                end
                S_OUT: if (!o_valid_reg || m_ready) begin
                    o_valid_reg <= 1'b1;
                    o_bnd_reg   <= bnd_reg;
                    o_hash_reg  <= h_reg;
                    o_last_reg  <= (seg_reg == SW'(cdc_pkg::Segments - 1));
                    if (seg_reg == SW'(cdc_pkg::Segments - 1)) begin
                        for (int i = 0; i < cdc_pkg::Segments; i++) table_reg[i] <= '0;
                        state_reg <= S_FILL;
                    end else begin
                        seg_reg   <= seg_reg + 1'b1;
                        state_reg <= S_SEG;
                    end
                end
                default: state_reg <= S_FILL;
            endcase
            if (o_valid_reg && m_ready && !(state_reg == S_OUT)) o_valid_reg <= 1'b0;
        end
    end
endmodule
